/* design/drrd_pkg.sv */
// ----------------------------------------------------------------------------
// drrd_pkg
// Shared types and constants for the dirty row run detector.
// ----------------------------------------------------------------------------
package drrd_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam int ROW_W   = 10;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_RUN     = 2'd1,
        KIND_DONE    = 2'd2
    } t_kind;

    // Row event handed from front to back
    typedef struct packed {
        logic [31:0]      hash;
        logic [ROW_W-1:0] row;
        logic             beyond;
        logic             full;
        logic             fstart;
        logic             rend;
        logic             fend;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [8:0]  row_index;
        logic        row_changed;
        logic [11:0] run_start;
        logic [3:0]  run_count;
        logic [11:0] rows_written;
        logic        overflow;
        logic        last;
    } t_result;

endpackage

/* design/drrd_if.sv */
// ----------------------------------------------------------------------------
// drrd_if
// Valid/ready stream interfaces for the input words and the results.
// ----------------------------------------------------------------------------
interface drrd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic        unit_kind;
    logic        frame_start;
    logic        force_full;
    logic        row_end;
    logic        frame_end;

    modport source (
        output valid, data_word, unit_kind, frame_start, force_full, row_end, frame_end,
        input  ready
    );
    modport sink (
        input  valid, data_word, unit_kind, frame_start, force_full, row_end, frame_end,
        output ready
    );
endinterface

interface drrd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [8:0]  row_index;
    logic        row_changed;
    logic [11:0] run_start;
    logic [3:0]  run_count;
    logic [11:0] rows_written;
    logic        overflow;
    logic        last;

    modport source (
        output valid, kind, row_index, row_changed, run_start, run_count,
               rows_written, overflow, last,
        input  ready
    );
    modport sink (
        input  valid, kind, row_index, row_changed, run_start, run_count,
               rows_written, overflow, last,
        output ready
    );
endinterface

/* design/drrd_front.sv */
// ----------------------------------------------------------------------------
// drrd_front
// Accepts words, runs the FNV-1a hash chain, tracks frame and row position
// and pushes one event per frame start or row end into the queue.
// ----------------------------------------------------------------------------
module drrd_front
    import drrd_pkg::*;
#(
    parameter int STORE_ROWS     = 512,
    parameter int REFRESH_PERIOD = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    drrd_in_if.sink       i_in,
    input  logic          i_q_ready,
    output logic          o_push,
    output t_entry        o_entry
);

    logic [31:0]      r_hash, n_hash;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_past, n_past;
    logic             r_sv, n_sv;
    logic             r_full, n_full;
    logic [5:0]       r_fc, n_fc;

    logic             w_acc;
    logic             w_sv0;
    logic [6:0]       w_fc_inc;
    logic [31:0]      w_h0, w_hx, w_hm;
    logic [ROW_W-1:0] w_row0;
    logic             w_past0;
    logic             w_rend;

    assign i_in.ready = i_q_ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_rend     = i_in.row_end || i_in.frame_end;
    assign o_push     = w_acc && (i_in.frame_start || w_rend);

    assign w_h0 = i_in.frame_start ? FNV_BASIS : r_hash;
    assign w_hx = w_h0 ^ (i_in.unit_kind ? {24'd0, i_in.data_word[7:0]} : i_in.data_word);
    assign w_hm = w_hx * FNV_PRIME;

    always_comb begin
        w_sv0    = (i_in.frame_start && i_in.force_full) ? 1'b0 : r_sv;
        w_fc_inc = {1'b0, r_fc} + 7'd1;
        w_row0   = i_in.frame_start ? '0 : r_row;
        w_past0  = i_in.frame_start ? 1'b0 : r_past;

        n_sv   = w_sv0;
        n_full = r_full;
        n_fc   = r_fc;
        if (i_in.frame_start) begin
            n_full = !w_sv0 || (r_fc == 6'd0);
            n_fc   = (w_fc_inc >= 7'(REFRESH_PERIOD)) ? 6'd0 : w_fc_inc[5:0];
        end

        n_hash = w_hm;
        n_row  = w_row0;
        n_past = w_past0;
        if (w_rend) begin
            n_hash = FNV_BASIS;
            if (w_row0 == {ROW_W{1'b1}}) begin
                n_past = 1'b1;
            end else begin
                n_row = w_row0 + 1'b1;
            end
        end
        if (i_in.frame_end) begin
            n_sv   = 1'b1;
            n_row  = '0;
            n_past = 1'b0;
        end

        o_entry.hash   = w_hm;
        o_entry.row    = w_row0;
        o_entry.beyond = w_past0 || ({1'b0, w_row0} >= 11'(STORE_ROWS));
        o_entry.full   = n_full || !w_sv0;
        o_entry.fstart = i_in.frame_start;
        o_entry.rend   = w_rend;
        o_entry.fend   = i_in.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
            r_row  <= '0;
            r_past <= 1'b0;
            r_sv   <= 1'b0;
            r_full <= 1'b0;
            r_fc   <= '0;
        end else if (w_acc) begin
            r_hash <= n_hash;
            r_row  <= n_row;
            r_past <= n_past;
            r_sv   <= n_sv;
            r_full <= n_full;
            r_fc   <= n_fc;
        end
    end

endmodule

/* design/drrd_queue.sv */
// ----------------------------------------------------------------------------
// drrd_queue
// Short FIFO of row events between the front and the back.
// ----------------------------------------------------------------------------
module drrd_queue
    import drrd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_pop
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            w_do_pop;

    assign o_ready  = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_entry  = r_mem[r_rp];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(w_do_pop);
        end
    end

endmodule

/* design/drrd_back.sv */
// ----------------------------------------------------------------------------
// drrd_back
// Compares row hashes against the store, builds runs of changed panel rows
// and issues the results of one event into an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module drrd_back
    import drrd_pkg::*;
#(
    parameter int STORE_ROWS  = 512,
    parameter int ROW_SCALE   = 1,
    parameter int STAGE_DEPTH = 8,
    parameter int ROW_BASE    = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [8:0] i_dest_row,
    input  logic       i_q_valid,
    input  t_entry     i_q_entry,
    output logic       o_q_pop,
    output logic       o_res_valid,
    output t_result    o_res,
    input  logic       i_res_ready
);

    localparam int AW = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;

    function automatic logic [11:0] sat_add(logic [11:0] a, logic [3:0] b);
        logic [12:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[12] ? 12'hFFF : s[11:0];
    endfunction

    logic [31:0] r_store [STORE_ROWS];
    logic [31:0] r_rdata;
    logic        r_fwd;
    logic [31:0] r_fwd_hash;

    logic        r_bv;
    t_entry      r_b;
    logic [1:0]  r_ph;

    logic [3:0]  r_staged;
    logic [11:0] r_start;
    logic [11:0] r_wt;
    logic        r_ovf;

    logic        r_ov;
    t_result     r_out;

    logic [31:0] w_stored;
    logic [3:0]  w_bst, w_st1, w_st_keep;
    logic [11:0] w_bstart, w_start1, w_bwt, w_wt1, w_wt2;
    logic        w_bovf, w_ovf1;
    logic        w_dirty, w_cond;
    logic [12:0] w_py_full;
    logic [11:0] w_py;
    logic [3:0]  w_cv;
    t_result     w_cand [4];
    t_result     w_pick;
    logic        w_has, w_more;
    logic [1:0]  w_sel;
    logic        w_space, w_emit, w_retire, w_wr;
    logic [AW-1:0] w_raddr, w_waddr;

    assign w_stored  = r_fwd ? r_fwd_hash : r_rdata;
    assign w_py_full = 13'(ROW_BASE) + (13'(i_dest_row) + 13'(r_b.row)) * 13'(ROW_SCALE);
    assign w_py      = w_py_full[11:0];

    always_comb begin
        w_bst    = r_b.fstart ? 4'd0  : r_staged;
        w_bstart = r_b.fstart ? 12'd0 : r_start;
        w_bwt    = r_b.fstart ? 12'd0 : r_wt;
        w_bovf   = r_b.fstart ? 1'b0  : r_ovf;

        w_dirty = r_b.beyond || r_b.full || (w_stored != r_b.hash);
        w_cond  = (({1'b0, w_bst} + 5'(ROW_SCALE)) > 5'(STAGE_DEPTH)) ||
                  ((w_bst != 4'd0) && (12'(w_bstart + {8'd0, w_bst}) != w_py));

        w_cv[0] = r_b.rend;
        w_cv[1] = r_b.rend && (w_bst != 4'd0) && (!w_dirty || w_cond);

        w_st_keep = w_cond ? 4'd0 : w_bst;
        w_st1     = w_bst;
        w_start1  = w_bstart;
        if (r_b.rend) begin
            if (!w_dirty) begin
                w_st1    = 4'd0;
                w_start1 = 12'd0;
            end else begin
                w_st1    = 4'(w_st_keep + 4'(ROW_SCALE));
                w_start1 = (w_st_keep == 4'd0) ? w_py : w_bstart;
            end
        end
        w_wt1  = w_cv[1] ? sat_add(w_bwt, w_bst) : w_bwt;
        w_ovf1 = w_bovf || (r_b.rend && r_b.beyond);

        w_cv[2] = r_b.fend && (w_st1 != 4'd0);
        w_wt2   = w_cv[2] ? sat_add(w_wt1, w_st1) : w_wt1;
        w_cv[3] = r_b.fend;

        for (int k = 0; k < 4; k++) begin
            w_cand[k] = '0;
        end
        w_cand[0].kind        = KIND_VERDICT;
        w_cand[0].row_index   = r_b.row[8:0];
        w_cand[0].row_changed = w_dirty;
        w_cand[1].kind        = KIND_RUN;
        w_cand[1].run_start   = w_bstart;
        w_cand[1].run_count   = w_bst;
        w_cand[2].kind        = KIND_RUN;
        w_cand[2].run_start   = w_start1;
        w_cand[2].run_count   = w_st1;
        w_cand[3].kind         = KIND_DONE;
        w_cand[3].rows_written = w_wt2;
        w_cand[3].overflow     = w_ovf1;

        w_has = 1'b0;
        w_sel = 2'd0;
        for (int p = 0; p < 4; p++) begin
            if (!w_has && w_cv[p] && (2'(p) >= r_ph)) begin
                w_has = 1'b1;
                w_sel = 2'(p);
            end
        end
        w_more = 1'b0;
        for (int p = 0; p < 4; p++) begin
            if (w_has && w_cv[p] && (2'(p) > w_sel)) begin
                w_more = 1'b1;
            end
        end

        w_pick      = w_cand[w_sel];
        w_pick.last = !w_more;
    end

    assign w_space  = !r_ov || i_res_ready;
    assign w_emit   = r_bv && w_has && w_space;
    assign w_retire = r_bv && (!w_has || (w_emit && !w_more));
    assign o_q_pop  = !r_bv || w_retire;
    assign w_wr     = w_retire && r_b.rend && !r_b.beyond;
    assign w_raddr  = i_q_entry.row[AW-1:0];
    assign w_waddr  = r_b.row[AW-1:0];

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_store[w_waddr] <= r_b.hash;
        end
        if (o_q_pop && i_q_valid) begin
            r_rdata    <= r_store[w_raddr];
            r_fwd      <= w_wr && (w_waddr == w_raddr);
            r_fwd_hash <= r_b.hash;
            r_b        <= i_q_entry;
        end
        if (w_emit) begin
            r_out <= w_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv     <= 1'b0;
            r_ph     <= 2'd0;
            r_staged <= '0;
            r_start  <= '0;
            r_wt     <= '0;
            r_ovf    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_bv <= i_q_valid;
            end
            if (w_retire) begin
                r_ph <= 2'd0;
                if (r_b.fend) begin
                    r_staged <= '0;
                    r_start  <= '0;
                    r_wt     <= '0;
                    r_ovf    <= 1'b0;
                end else begin
                    r_staged <= w_st1;
                    r_start  <= w_start1;
                    r_wt     <= w_wt1;
                    r_ovf    <= w_ovf1;
                end
            end else if (w_emit) begin
                r_ph <= w_sel + 2'd1;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

/* design/dirty_row_run_detector.sv */
// ----------------------------------------------------------------------------
// dirty_row_run_detector
// FNV-1a row hashing with dirty row detection and run grouping.
//
//   channel  dir  handshake        payload
//   i_in     in   valid/ready      data_word, unit_kind, frame/row flags
//   o_out    out  valid/ready      kind, verdict, run and frame fields
//   cfg      in   i_cfg_we         i_cfg_wdata = dest_row
//
// One word per cycle if the queue has room; hash xor/multiply is combinational.
// A row end yields 1 to 4 results, drained one per cycle through the output
// register while o_out.ready allows; a 4-entry event queue absorbs bursts,
// ready drops when it fills. A verdict passes the event queue, r_b and r_out.
// Reset is synchronous; the hash store needs no clearing pass.
// ----------------------------------------------------------------------------
module dirty_row_run_detector
    import drrd_pkg::*;
#(
    parameter int STORE_ROWS     = 512,
    parameter int ROW_SCALE      = 1,
    parameter int STAGE_DEPTH    = 8,
    parameter int ROW_BASE       = 0,
    parameter int REFRESH_PERIOD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    drrd_in_if.sink     i_in,
    drrd_out_if.source  o_out
);

    logic [8:0] r_dest_row;
    logic       w_push, w_q_ready, w_q_valid, w_pop, w_res_valid;
    t_entry     w_push_entry, w_head;
    t_result    w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_row <= '0;
        end else if (i_cfg_we) begin
            r_dest_row <= i_cfg_wdata;
        end
    end

    drrd_front #(
        .STORE_ROWS     (STORE_ROWS),
        .REFRESH_PERIOD (REFRESH_PERIOD)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_entry   (w_push_entry)
    );

    drrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_entry (w_head),
        .i_pop   (w_pop)
    );

    drrd_back #(
        .STORE_ROWS  (STORE_ROWS),
        .ROW_SCALE   (ROW_SCALE),
        .STAGE_DEPTH (STAGE_DEPTH),
        .ROW_BASE    (ROW_BASE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dest_row  (r_dest_row),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_head),
        .o_q_pop     (w_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (o_out.ready)
    );

    assign o_out.valid        = w_res_valid;
    assign o_out.kind         = w_res.kind;
    assign o_out.row_index    = w_res.row_index;
    assign o_out.row_changed  = w_res.row_changed;
    assign o_out.run_start    = w_res.run_start;
    assign o_out.run_count    = w_res.run_count;
    assign o_out.rows_written = w_res.rows_written;
    assign o_out.overflow     = w_res.overflow;
    assign o_out.last         = w_res.last;

endmodule

/* design/drrd_checker.sv */
// ----------------------------------------------------------------------------
// drrd_checker
// Port-level checks on the result stream of the detector.
// ----------------------------------------------------------------------------
module drrd_checker
    import drrd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [8:0]  i_row_index,
    input logic        i_row_changed,
    input logic [11:0] i_run_start,
    input logic [3:0]  i_run_count,
    input logic [11:0] i_rows_written,
    input logic        i_overflow,
    input logic        i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_row_index) &&
        $stable(i_row_changed) && $stable(i_run_start) && $stable(i_run_count) &&
        $stable(i_rows_written) && $stable(i_overflow) && $stable(i_last))
        else $error("result changed while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_DONE) |-> i_last)
        else $error("frame done is not the last result");

    a_run_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_RUN) |->
        (i_run_count != 4'd0) && (i_row_index == 9'd0) && !i_row_changed)
        else $error("bad run result");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last |=> i_valid)
        else $error("gap inside a result group");

endmodule

bind dirty_row_run_detector drrd_checker u_drrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_kind         (o_out.kind),
    .i_row_index    (o_out.row_index),
    .i_row_changed  (o_out.row_changed),
    .i_run_start    (o_out.run_start),
    .i_run_count    (o_out.run_count),
    .i_rows_written (o_out.rows_written),
    .i_overflow     (o_out.overflow),
    .i_last         (o_out.last)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dirty_row_run_detector. Word requests come from
// a queue filled phase by phase. Each accepted request runs through an
// in-bench hash and run-grouping model. Every output is matched against
// the oldest predicted report, with random idling on both sides and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drrd_pkg::*;

    localparam int STORE_ROWS     = 512;
    localparam int ROW_SCALE      = 1;
    localparam int STAGE_DEPTH    = 8;
    localparam int ROW_BASE       = 0;
    localparam int REFRESH_PERIOD = 64;
    localparam int SETTLE_CYC     = 12;
    localparam int HOLD_CYC       = 400;

    typedef struct packed {
        logic [31:0] word;
        logic        unit_kind;
        logic        fs;
        logic        ff;
        logic        re;
        logic        fe;
    } t_req;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [8:0] i_cfg_wdata;

    drrd_in_if  in_if ();
    drrd_out_if out_if ();

    dirty_row_run_detector #(
        .STORE_ROWS     (STORE_ROWS),
        .ROW_SCALE      (ROW_SCALE),
        .STAGE_DEPTH    (STAGE_DEPTH),
        .ROW_BASE       (ROW_BASE),
        .REFRESH_PERIOD (REFRESH_PERIOD)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_req    word_feed[$];
    t_result due_reports[$];
    t_req    cur_req;

    int idle_pct    = 0;
    int stall_pct   = 0;
    bit hold_arm    = 0;
    bit hold_done   = 0;
    int rx_hold_left = 0;

    // model state
    int          m_dest;
    logic [31:0] m_hash;
    logic [31:0] m_store [STORE_ROWS];
    bit          m_valid;
    int          m_fcnt;
    bit          m_full;
    int          m_row;
    bit          m_past;
    int          m_staged;
    int          m_sstart;
    int          m_total;
    bit          m_ovf;

    // stimulus bookkeeping: rows 0..hwm-1 of the store hold a hash
    int          hwm;
    int          gen_row;
    bit          gen_valid;
    bit          gen_safe;
    logic [32:0] cur_row[$];
    logic [32:0] saved_row [STORE_ROWS][$];

    int n_words, n_verdicts, n_same, n_runs, n_frames, n_ovf_frames, n_sat_frames;
    int n_bad;

    function automatic void clear_frame_state();
        m_hash   = FNV_BASIS;
        m_row    = 0;
        m_past   = 0;
        m_staged = 0;
        m_sstart = 0;
        m_total  = 0;
        m_ovf    = 0;
    endfunction

    function automatic void close_open_run(ref t_result res[$]);
        t_result v;
        if (m_staged > 0) begin
            v = '0;
            v.kind = KIND_RUN;
            v.run_start = m_sstart[11:0];
            v.run_count = m_staged[3:0];
            res.push_back(v);
            m_total += m_staged;
            if (m_total > 4095) m_total = 4095;
            n_runs++;
        end
        m_staged = 0;
        m_sstart = 0;
    endfunction

    function automatic void hash_and_group(t_req r);
        t_result     res[$];
        t_result     v;
        logic [31:0] mix;
        int          idx;
        int          py;
        bit          dirty;
        if (r.fs) begin
            if (r.ff) m_valid = 0;
            m_full = !m_valid || m_fcnt == 0;
            m_fcnt = (m_fcnt + 1 >= REFRESH_PERIOD) ? 0 : m_fcnt + 1;
            clear_frame_state();
        end
        mix = r.unit_kind ? {24'd0, r.word[7:0]} : r.word;
        m_hash = (m_hash ^ mix) * FNV_PRIME;
        if (r.re || r.fe) begin
            idx = m_row & 'h3FF;
            if (m_past || idx >= STORE_ROWS) begin
                m_ovf = 1;
                dirty = 1;
            end else begin
                dirty = m_full || !m_valid || m_hash != m_store[idx];
                m_store[idx] = m_hash;
            end
            v = '0;
            v.kind = KIND_VERDICT;
            v.row_index = idx[8:0];
            v.row_changed = dirty;
            res.push_back(v);
            n_verdicts++;
            if (!dirty) begin
                n_same++;
                close_open_run(res);
            end else begin
                py = (ROW_BASE + (m_dest + idx) * ROW_SCALE) & 'hFFF;
                if (m_staged + ROW_SCALE > STAGE_DEPTH ||
                    (m_staged > 0 && ((m_sstart + m_staged) & 'hFFF) != py))
                    close_open_run(res);
                if (m_staged == 0) m_sstart = py;
                m_staged = (m_staged + ROW_SCALE) & 'hF;
            end
            if (m_row >= 1023) begin
                m_row = 1023;
                m_past = 1;
            end else begin
                m_row++;
            end
            m_hash = FNV_BASIS;
        end
        if (r.fe) begin
            close_open_run(res);
            v = '0;
            v.kind = KIND_DONE;
            v.rows_written = m_total[11:0];
            v.overflow = m_ovf;
            res.push_back(v);
            n_frames++;
            if (m_ovf) n_ovf_frames++;
            if (m_total == 4095) n_sat_frames++;
            m_valid = 1;
            clear_frame_state();
        end
        if (res.size() > 0) res[res.size()-1].last = 1;
        foreach (res[i]) due_reports.push_back(res[i]);
    endfunction

    // Queues one request; keeps the stimulus off store entries never written.
    function automatic void queue_word(logic [31:0] w, bit k, bit fs, bit ff, bit re, bit fe);
        t_req r;
        if (fs) begin
            if (ff) gen_valid = 0;
            gen_safe = !gen_valid;
            gen_row = 0;
            cur_row.delete();
        end
        cur_row.push_back({k, w});
        if ((re || fe) && !gen_safe && gen_row < STORE_ROWS && gen_row >= hwm) begin
            re = 0;
            fe = 0;
        end
        if (re || fe) begin
            if (gen_row < STORE_ROWS) begin
                saved_row[gen_row] = cur_row;
                if (gen_row >= hwm) hwm = gen_row + 1;
            end
            gen_row++;
            cur_row.delete();
        end
        if (fe) begin
            gen_valid = 1;
            gen_safe = 0;
            gen_row = 0;
        end
        r.word = w;
        r.unit_kind = k;
        r.fs = fs;
        r.ff = ff;
        r.re = re;
        r.fe = fe;
        word_feed.push_back(r);
    endfunction

    function automatic logic [32:0] rand_unit();
        logic [31:0] w;
        case ($urandom_range(9))
            0:       w = 32'h0000_0000;
            1:       w = 32'hFFFF_FFFF;
            default: w = $urandom;
        endcase
        return {($urandom_range(99) < 20) ? 1'b1 : 1'b0, w};
    endfunction

    function automatic void queue_frame(int rows, bit force_it, int reuse_pct);
        logic [32:0] row_items[$];
        bit          drop_end, fend_only, fs, fe, re, last_item;
        int          len;
        if (!force_it && gen_valid && rows > hwm) rows = hwm;
        drop_end = ($urandom_range(99) < 6);
        fend_only = 1'($urandom_range(1));
        for (int r = 0; r < rows; r++) begin
            row_items.delete();
            if (r < hwm && saved_row[r].size() != 0 && $urandom_range(99) < reuse_pct) begin
                row_items = saved_row[r];
            end else begin
                len = ($urandom_range(99) < 60) ? 1 : $urandom_range(2, 4);
                repeat (len) row_items.push_back(rand_unit());
            end
            foreach (row_items[i]) begin
                fs = (r == 0 && i == 0);
                last_item = (i == row_items.size() - 1);
                fe = last_item && r == rows - 1 && !drop_end;
                re = last_item && !(fe && fend_only);
                queue_word(row_items[i][31:0], row_items[i][32], fs,
                           fs ? force_it : ($urandom_range(99) < 4), re, fe);
            end
        end
    endfunction

    function automatic void queue_random(int target);
        int start;
        logic [32:0] u;
        start = word_feed.size();
        while (word_feed.size() - start < target) begin
            if ($urandom_range(99) < 88) begin
                queue_frame($urandom_range(1, 6), $urandom_range(99) < 8, 60);
            end else begin
                u = rand_unit();
                queue_word(u[31:0], u[32], 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           $urandom_range(99) < 10);
            end
        end
    endfunction

    task automatic settle(int extra);
        while (word_feed.size() != 0 || in_if.valid || due_reports.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_dest_row(int v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v[8:0];
        m_dest = v & 'h1FF;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic set_pace(int idle, int stall);
        idle_pct <= idle;
        stall_pct <= stall;
    endtask

    function automatic void check_report(t_result got);
        t_result want;
        if (due_reports.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
                $display("%0t: unexpected report kind %0d row %0d start %0d count %0d",
                         $realtime, got.kind, got.row_index, got.run_start, got.run_count);
            return;
        end
        want = due_reports.pop_front();
        if (got.kind != want.kind || got.row_index != want.row_index ||
            got.row_changed != want.row_changed || got.run_start != want.run_start ||
            got.run_count != want.run_count || got.rows_written != want.rows_written ||
            got.overflow != want.overflow || got.last != want.last) begin
            n_bad++;
            if (n_bad <= 10) begin
                $display("%0t: mismatch exp kind %0d row %0d chg %0d start %0d cnt %0d",
                         $realtime, want.kind, want.row_index, want.row_changed,
                         want.run_start, want.run_count);
                $display("    exp total %0d ovf %0d last %0d | got kind %0d row %0d chg %0d",
                         want.rows_written, want.overflow, want.last,
                         got.kind, got.row_index, got.row_changed);
                $display("    got start %0d cnt %0d total %0d ovf %0d last %0d",
                         got.run_start, got.run_count, got.rows_written,
                         got.overflow, got.last);
            end
        end
    endfunction

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                hash_and_group(cur_req);
                n_words++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (word_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_req = word_feed.pop_front();
                    in_if.valid <= 1;
                    in_if.data_word <= cur_req.word;
                    in_if.unit_kind <= cur_req.unit_kind;
                    in_if.frame_start <= cur_req.fs;
                    in_if.force_full <= cur_req.ff;
                    in_if.row_end <= cur_req.re;
                    in_if.frame_end <= cur_req.fe;
                end else begin
                    in_if.valid <= 0;
                end
            end
        end
    end

    // report monitor
    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            out_if.ready <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.kind = t_kind'(out_if.kind);
                got.row_index = out_if.row_index;
                got.row_changed = out_if.row_changed;
                got.run_start = out_if.run_start;
                got.run_count = out_if.run_count;
                got.rows_written = out_if.rows_written;
                got.overflow = out_if.overflow;
                got.last = out_if.last;
                check_report(got);
            end
            out_if.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // long output hold-off, armed once
    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            rx_hold_left <= HOLD_CYC;
            hold_done <= 1;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    initial begin
        #2ms;
        $display("%0t: timeout, %0d reports still due", $realtime, due_reports.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = '0;
        in_if.valid = 0;
        in_if.data_word = '0;
        in_if.unit_kind = 0;
        in_if.frame_start = 0;
        in_if.force_full = 0;
        in_if.row_end = 0;
        in_if.frame_end = 0;
        out_if.ready = 0;
        m_dest = 0;
        m_valid = 0;
        m_fcnt = 0;
        m_full = 0;
        clear_frame_state();
        hwm = 0;
        gen_row = 0;
        gen_valid = 0;
        gen_safe = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // rows before any frame start, store still invalid; force alone is ignored
        queue_word(32'h0000_0000, 0, 0, 0, 1, 0);
        queue_word(32'hFFFF_FFFF, 1, 0, 1, 1, 0);
        // forced frame of 11 rows: runs split at the staging depth
        queue_word(32'hFFFF_FFFF, 0, 1, 1, 0, 0);
        queue_word(32'h0000_0000, 1, 0, 0, 1, 0);
        for (int r = 1; r < 10; r++) queue_word($urandom, 1'($urandom_range(1)), 0, 0, 1, 0);
        // frame end without row end
        queue_word($urandom, 0, 0, 0, 0, 1);
        // same rows again, some changed: unchanged rows close runs
        queue_frame(11, 0, 80);
        settle(SETTLE_CYC);

        write_dest_row(511);
        set_pace(0, 0);
        hold_arm <= 1;
        queue_random(100);
        settle(SETTLE_CYC);

        write_dest_row($urandom_range(1, 510));
        set_pace(70, 0);
        queue_random(100);
        settle(SETTLE_CYC);

        write_dest_row(0);
        set_pace(0, 70);
        queue_random(100);
        settle(SETTLE_CYC);

        write_dest_row(255);
        set_pace(12, 12);
        queue_random(100);
        settle(SETTLE_CYC);

        set_pace(12, 12);
        queue_random(20);
        settle(SETTLE_CYC * 2);

        n_bad += due_reports.size();
        $display("Run covered %0d words, %0d frames, %0d row verdicts (%0d unchanged), %0d runs",
                 n_words, n_frames, n_verdicts, n_same, n_runs);
        $display("Frames with overflow: %0d, with saturated total: %0d, errors: %0d",
                 n_ovf_frames, n_sat_frames, n_bad);
        if (n_bad == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
